@@ rtl/lmi_pkg.sv @@
// Shared types, codes and constants for the leg motion interpolator.
// No dependencies; every other file of the block but lmi_ram imports this package.
`timescale 1ns / 1ps
`default_nettype none
package lmi_pkg;

  localparam int NUM_LIMBS_DEF = 4;

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_MOVE  = 2'd1;
  localparam logic [1:0] KIND_PLACE = 2'd2;

  localparam logic [1:0] CFG_STEP_SPEED = 2'd0;
  localparam logic [1:0] CFG_HIP_OFFSET = 2'd1;
  localparam logic [1:0] CFG_MIRROR     = 2'd2;
  localparam logic [1:0] CFG_FLIP       = 2'd3;

  localparam int ANG90  = 5760;
  localparam int ANG180 = 11520;

  // iterative unit widths
  localparam int SQ_IN_W   = 34;
  localparam int SQ_OUT_W  = 17;
  localparam int DIV_NUM_W = 30;
  localparam int DIV_DEN_W = 18;
  localparam int CD_IN_W   = 18;
  localparam int CD_W      = 34;
  localparam int CD_Z_W    = 32;

  typedef logic signed [15:0] pos_t;

  typedef struct packed {
    pos_t cur;
    pos_t tgt;
    pos_t step;
  } entry_t;

  // atan(2^-i) in 1/65536 degree
  function automatic logic signed [CD_Z_W-1:0] atan_step(input logic [3:0] i);
    logic signed [CD_Z_W-1:0] v;
    case (i)
      4'd0:    v = 32'sd2949120;
      4'd1:    v = 32'sd1740967;
      4'd2:    v = 32'sd919879;
      4'd3:    v = 32'sd466945;
      4'd4:    v = 32'sd234379;
      4'd5:    v = 32'sd117304;
      4'd6:    v = 32'sd58666;
      4'd7:    v = 32'sd29335;
      4'd8:    v = 32'sd14668;
      4'd9:    v = 32'sd7334;
      4'd10:   v = 32'sd3667;
      4'd11:   v = 32'sd1833;
      4'd12:   v = 32'sd917;
      4'd13:   v = 32'sd458;
      4'd14:   v = 32'sd229;
      default: v = 32'sd115;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

@@ rtl/lmi_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module lmi_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 12
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/lmi_sqrt.sv @@
// Iterative integer square root, two radicand bits per cycle.
// Depends on lmi_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none
module lmi_sqrt import lmi_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [SQ_IN_W-1:0]  radicand,
  output logic                     busy,
  output logic                     done,
  output logic [SQ_OUT_W-1:0]      root
);

  logic [SQ_IN_W-1:0]  v;
  logic [20:0]         rem;
  logic [4:0]          cnt;
  logic [20:0]         r2;
  logic [20:0]         trial;

  assign r2    = {rem[18:0], v[SQ_IN_W-1 -: 2]};
  assign trial = {2'b00, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'(SQ_OUT_W - 1);
        v    <= radicand;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        v <= {v[SQ_IN_W-3:0], 2'b00};
        if (r2 >= trial) begin
          rem  <= r2 - trial;
          root <= {root[SQ_OUT_W-2:0], 1'b1};
        end else begin
          rem  <= r2;
          root <= {root[SQ_OUT_W-2:0], 1'b0};
        end
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - 5'd1;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/lmi_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on lmi_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none
module lmi_div import lmi_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [DIV_NUM_W-1:0] num,
  input  wire logic [DIV_DEN_W-1:0] den,
  output logic                      busy,
  output logic                      done,
  output logic [DIV_NUM_W-1:0]      quot
);

  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] dreg;
  logic [4:0]           cnt;
  logic [DIV_DEN_W:0]   r2;

  assign r2 = {rem, quot[DIV_NUM_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'(DIV_NUM_W - 1);
        quot <= num;
        rem  <= '0;
        dreg <= den;
      end else if (busy) begin
        // quotient bits shift in where numerator bits shift out
        if (r2 >= {1'b0, dreg}) begin
          rem  <= DIV_DEN_W'(r2 - {1'b0, dreg});
          quot <= {quot[DIV_NUM_W-2:0], 1'b1};
        end else begin
          rem  <= r2[DIV_DEN_W-1:0];
          quot <= {quot[DIV_NUM_W-2:0], 1'b0};
        end
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - 5'd1;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/lmi_cordic.sv @@
// Vectoring CORDIC atan2, one micro-rotation per cycle, 16 iterations.
// Depends on lmi_pkg for the arctangent table and widths.
`timescale 1ns / 1ps
`default_nettype none
module lmi_cordic import lmi_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic signed [CD_IN_W-1:0] y_in,
  input  wire logic signed [CD_IN_W-1:0] x_in,
  output logic                           busy,
  output logic                           done,
  output logic signed [15:0]             angle
);

  logic signed [CD_W-1:0]   x;
  logic signed [CD_W-1:0]   y;
  logic signed [CD_Z_W-1:0] z;
  logic [3:0]               i;
  logic                     zero;
  logic signed [CD_W-1:0]   xs;
  logic signed [CD_W-1:0]   ys;
  logic signed [CD_W-1:0]   xsh;
  logic signed [CD_W-1:0]   ysh;
  logic signed [CD_Z_W-1:0] zf;
  logic signed [CD_Z_W-11:0] a;

  assign xs  = {{(CD_W-CD_IN_W-12){x_in[CD_IN_W-1]}}, x_in, 12'b0};
  assign ys  = {{(CD_W-CD_IN_W-12){y_in[CD_IN_W-1]}}, y_in, 12'b0};
  assign xsh = x >>> i;
  assign ysh = y >>> i;
  assign zf  = z + CD_Z_W'(512);
  assign a   = zf[CD_Z_W-1:10];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        i    <= 4'd0;
        zero <= (x_in == '0) && (y_in == '0);
        // turn left half-plane vectors by 180 degrees first
        if (x_in[CD_IN_W-1]) begin
          x <= -xs;
          y <= -ys;
          z <= y_in[CD_IN_W-1] ? -CD_Z_W'(180 * 65536) : CD_Z_W'(180 * 65536);
        end else begin
          x <= xs;
          y <= ys;
          z <= '0;
        end
      end else if (busy) begin
        if (y[CD_W-1]) begin
          x <= x - ysh;
          y <= y + xsh;
          z <= z - atan_step(i);
        end else begin
          x <= x + ysh;
          y <= y - xsh;
          z <= z + atan_step(i);
        end
        i <= i + 4'd1;
        if (i == 4'd15) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (zero) begin
      angle = '0;
    end else if (a > (CD_Z_W-10)'(ANG180)) begin
      angle = 16'(ANG180);
    end else if (a < -(CD_Z_W-10)'(ANG180)) begin
      angle = -16'(ANG180);
    end else begin
      angle = a[15:0];
    end
  end

endmodule
`default_nettype wire

@@ rtl/leg_motion_interpolator_ik_top.sv @@
// Leg motion interpolator with servo angle solver: sequencer, state RAM and output register.
// Depends on lmi_pkg, lmi_ram, lmi_sqrt, lmi_div and lmi_cordic.
//
//  channel  | direction | handshake          | content
//  s_*      | in        | s_tvalid/s_tready  | move, place or tick item (kind in tuser)
//  m_*      | out       | m_tvalid/m_tready  | servo angle result, tlast on final one of a tick
//  cfg_*    | in        | cfg_we             | register index and data, no read-back
//
// One item at a time; s_tready is high only while the sequencer is idle.
// Place: reads and writes three RAM entries, one port each.
// Move: set by one square root and three divides.
// Tick: per limb, a square root plus two CORDIC passes, and longer
// while m_tready holds the output register full.
// Reset is synchronous; RAM entries read as zero until first written.
`timescale 1ns / 1ps
`default_nettype none
module leg_motion_interpolator_ik_top import lmi_pkg::*; #(
  parameter int NUM_LIMBS = NUM_LIMBS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // limb[1:0], target_x[17:2], target_y[33:18], target_z[49:34],
  // keep_x[50], keep_y[51], keep_z[52], zero fill [55:53]
  input  wire logic [55:0] s_tdata,
  // kind[1:0]
  input  wire logic [1:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // out_limb[1:0], joint[2], angle[18:3], limb_reached[19], zero fill [23:20]
  output logic [23:0]      m_tdata,
  output logic             m_tlast,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [11:0] cfg_data
);

  localparam int DEPTH = NUM_LIMBS * 3;
  localparam int AW    = $clog2(DEPTH);
  localparam int LW    = ($clog2(NUM_LIMBS) > 2) ? $clog2(NUM_LIMBS) : 2;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_RD   = 5'd1;
  localparam logic [4:0] S_USE  = 5'd2;
  localparam logic [4:0] S_SQ   = 5'd3;
  localparam logic [4:0] S_SQW  = 5'd4;
  localparam logic [4:0] S_MUL  = 5'd5;
  localparam logic [4:0] S_DIVS = 5'd6;
  localparam logic [4:0] S_DIVW = 5'd7;
  localparam logic [4:0] S_WB   = 5'd8;
  localparam logic [4:0] S_MIR  = 5'd9;
  localparam logic [4:0] S_SX   = 5'd10;
  localparam logic [4:0] S_SY   = 5'd11;
  localparam logic [4:0] S_YAW  = 5'd12;
  localparam logic [4:0] S_CW0  = 5'd13;
  localparam logic [4:0] S_OUT0 = 5'd14;
  localparam logic [4:0] S_PIT  = 5'd15;
  localparam logic [4:0] S_CW1  = 5'd16;
  localparam logic [4:0] S_OUT1 = 5'd17;

  // configuration
  logic [11:0] step_speed;
  logic [11:0] hip_offset;
  logic [3:0]  mirror_mask;
  logic [3:0]  flip_pitch_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_speed      <= 12'd16;
      hip_offset      <= 12'd0;
      mirror_mask     <= 4'd6;
      flip_pitch_mask <= 4'd5;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_STEP_SPEED: step_speed      <= cfg_data;
        CFG_HIP_OFFSET: hip_offset      <= cfg_data;
        CFG_MIRROR:     mirror_mask     <= cfg_data[3:0];
        CFG_FLIP:       flip_pitch_mask <= cfg_data[3:0];
        default:        ;
      endcase
    end
  end

  // sequencer registers
  logic [4:0]           state;
  logic [1:0]           kind;
  logic [LW-1:0]        lcnt;
  logic [1:0]           ax;
  pos_t                 tin [3];
  logic                 keep [3];
  entry_t               ent [3];
  logic signed [16:0]   d [3];
  logic [SQ_IN_W-1:0]   sum;
  logic [SQ_OUT_W-1:0]  tot;
  logic [27:0]          prod;
  logic [15:0]          qmag;
  logic                 reached;
  logic signed [16:0]   px;
  logic signed [16:0]   py;
  pos_t                 pz;
  logic signed [17:0]   rr;
  logic signed [15:0]   ang;

  // state RAM with per-entry valid bits
  logic [AW-1:0]        addr;
  logic                 ram_we;
  logic                 ram_re;
  entry_t               ram_wdata;
  logic [$bits(entry_t)-1:0] ram_rdata;
  logic [DEPTH-1:0]     vld;
  logic                 rvld;
  entry_t               ent_rd;

  assign addr   = AW'(32'(lcnt) * 3 + 32'(ax));
  assign ram_re = (state == S_RD);
  assign ent_rd = rvld ? entry_t'(ram_rdata) : '0;

  lmi_ram #(.WIDTH($bits(entry_t)), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      rvld <= 1'b0;
    end else begin
      if (ram_we) begin
        vld[addr] <= 1'b1;
      end
      if (ram_re) begin
        rvld <= vld[addr];
      end
    end
  end

  // per-axis datapath on the entry just read
  pos_t               t_ax;
  logic               k_ax;
  logic signed [16:0] dn;
  logic signed [33:0] dsq;
  logic signed [16:0] diff;
  logic [16:0]        adiff;
  logic [16:0]        astep;
  logic signed [16:0] csum;
  pos_t               cnew;
  logic [15:0]        dabs;
  logic signed [33:0] sqx;
  logic signed [33:0] sqy;
  pos_t               qstep;

  assign t_ax  = tin[ax];
  assign k_ax  = keep[ax];
  assign dn    = k_ax ? 17'sd0 : (t_ax - ent_rd.cur);
  assign dsq   = dn * dn;
  assign diff  = ent_rd.cur - ent_rd.tgt;
  assign adiff = diff[16] ? 17'(-diff) : 17'(diff);
  assign astep = ent_rd.step[15] ? 17'(-17'(ent_rd.step)) : 17'(ent_rd.step);
  assign csum  = ent_rd.cur + ent_rd.step;
  assign dabs  = d[ax][16] ? 16'(-d[ax]) : d[ax][15:0];
  assign sqx   = px * px;
  assign sqy   = py * py;
  assign qstep = d[ax][16] ? -pos_t'(qmag) : pos_t'(qmag);

  always_comb begin
    if (adiff >= astep) begin
      // saturate on signed overflow of the 17-bit sum
      if (csum[16] != csum[15]) begin
        cnew = csum[16] ? -16'sd32768 : 16'sd32767;
      end else begin
        cnew = csum[15:0];
      end
    end else begin
      cnew = ent_rd.tgt;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = ent_rd;
    if (state == S_USE) begin
      if (kind == KIND_PLACE) begin
        ram_we    = 1'b1;
        ram_wdata = k_ax ? ent_rd : entry_t'{cur: t_ax, tgt: t_ax, step: ent_rd.step};
      end else if (kind == KIND_TICK) begin
        ram_we    = 1'b1;
        ram_wdata = '{cur: cnew, tgt: ent_rd.tgt, step: ent_rd.step};
      end
    end else if (state == S_WB) begin
      ram_we    = 1'b1;
      ram_wdata = '{cur: ent[ax].cur, tgt: k_ax ? ent[ax].tgt : t_ax, step: qstep};
    end
  end

  // shared iterative units
  logic                 sq_busy;
  logic                 sq_done;
  logic [SQ_OUT_W-1:0]  sq_root;
  logic                 dv_start;
  logic                 dv_busy;
  logic                 dv_done;
  logic [DIV_NUM_W-1:0] dv_quot;
  logic                 cd_start;
  logic                 cd_busy;
  logic                 cd_done;
  logic signed [15:0]   cd_angle;
  logic signed [CD_IN_W-1:0] cd_y;
  logic signed [CD_IN_W-1:0] cd_x;

  assign dv_start = (state == S_DIVS) && (tot != '0);
  assign cd_start = (state == S_YAW) || (state == S_PIT);
  assign cd_y     = (state == S_YAW) ? CD_IN_W'(py) : CD_IN_W'(pz);
  assign cd_x     = (state == S_YAW) ? CD_IN_W'(px) : rr;

  lmi_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_SQ),
    .radicand (sum),
    .busy     (sq_busy),
    .done     (sq_done),
    .root     (sq_root)
  );

  lmi_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (dv_start),
    .num   (DIV_NUM_W'({prod, 1'b0}) + DIV_NUM_W'(tot)),
    .den   ({tot, 1'b0}),
    .busy  (dv_busy),
    .done  (dv_done),
    .quot  (dv_quot)
  );

  lmi_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cd_start),
    .y_in  (cd_y),
    .x_in  (cd_x),
    .busy  (cd_busy),
    .done  (cd_done),
    .angle (cd_angle)
  );

  // output register
  logic out_free;
  logic load0;
  logic load1;
  logic is_last;

  assign out_free = !m_tvalid || m_tready;
  assign load0    = (state == S_OUT0) && out_free;
  assign load1    = (state == S_OUT1) && out_free;
  assign is_last  = (lcnt == LW'(NUM_LIMBS - 1));
  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load0 || load1) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load0 || load1) begin
      m_tdata <= {4'b0, reached, ang, load1, lcnt[1:0]};
      m_tlast <= load1 && is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            kind    <= s_tuser;
            tin[0]  <= s_tdata[17:2];
            tin[1]  <= s_tdata[33:18];
            tin[2]  <= s_tdata[49:34];
            keep[0] <= s_tdata[50];
            keep[1] <= s_tdata[51];
            keep[2] <= s_tdata[52];
            ax      <= 2'd0;
            sum     <= '0;
            reached <= 1'b1;
            if (s_tuser == KIND_TICK) begin
              lcnt  <= '0;
              state <= S_RD;
            end else if ((s_tuser == KIND_MOVE || s_tuser == KIND_PLACE) &&
                         ({2'b00, s_tdata[1:0]} < 4'(NUM_LIMBS))) begin
              lcnt  <= LW'(s_tdata[1:0]);
              state <= S_RD;
            end
          end
        end
        S_RD: state <= S_USE;
        S_USE: begin
          if (kind == KIND_MOVE) begin
            ent[ax] <= ent_rd;
            d[ax]   <= dn;
            sum     <= sum + unsigned'(dsq);
          end else if (kind == KIND_TICK) begin
            if (cnew != ent_rd.tgt) begin
              reached <= 1'b0;
            end
            case (ax)
              2'd0:    px <= 17'(cnew);
              2'd1:    py <= 17'(cnew);
              default: pz <= cnew;
            endcase
          end
          if (ax == 2'd2) begin
            ax <= 2'd0;
            if (kind == KIND_MOVE) begin
              state <= S_SQ;
            end else if (kind == KIND_TICK) begin
              state <= S_MIR;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            ax    <= ax + 2'd1;
            state <= S_RD;
          end
        end
        S_SQ: state <= S_SQW;
        S_SQW: begin
          if (sq_done) begin
            tot <= sq_root;
            rr  <= 18'(sq_root) - 18'(hip_offset);
            state <= (kind == KIND_MOVE) ? S_MUL : S_YAW;
          end
        end
        S_MUL: begin
          prod  <= dabs * step_speed;
          state <= S_DIVS;
        end
        S_DIVS: begin
          qmag  <= '0;
          state <= (tot == '0) ? S_WB : S_DIVW;
        end
        S_DIVW: begin
          if (dv_done) begin
            qmag  <= dv_quot[15:0];
            state <= S_WB;
          end
        end
        S_WB: begin
          if (ax == 2'd2) begin
            state <= S_IDLE;
          end else begin
            ax    <= ax + 2'd1;
            state <= S_MUL;
          end
        end
        S_MIR: begin
          if (mirror_mask[lcnt[1:0]]) begin
            px <= -px;
            py <= -py;
          end
          state <= S_SX;
        end
        S_SX: begin
          sum   <= SQ_IN_W'(unsigned'(sqx));
          state <= S_SY;
        end
        S_SY: begin
          sum   <= sum + unsigned'(sqy);
          state <= S_SQ;
        end
        S_YAW: state <= S_CW0;
        S_CW0: begin
          if (cd_done) begin
            ang   <= 16'(ANG90) + cd_angle;
            state <= S_OUT0;
          end
        end
        S_OUT0: begin
          if (out_free) begin
            state <= S_PIT;
          end
        end
        S_PIT: state <= S_CW1;
        S_CW1: begin
          if (cd_done) begin
            ang   <= flip_pitch_mask[lcnt[1:0]] ? 16'(ANG90) - cd_angle
                                                : 16'(ANG90) + cd_angle;
            state <= S_OUT1;
          end
        end
        S_OUT1: begin
          if (out_free) begin
            if (is_last) begin
              state <= S_IDLE;
            end else begin
              lcnt    <= lcnt + LW'(1);
              ax      <= 2'd0;
              reached <= 1'b1;
              state   <= S_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_idle_units: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !sq_busy && !dv_busy && !cd_busy)
    else $error("input taken while an iterative unit is busy");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_OUT0 || state == S_OUT1))
    else $error("result appeared outside an output step");

  a_last_pitch: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[2] && (m_tdata[1:0] == 2'(NUM_LIMBS - 1)))
    else $error("tlast not on the final pitch result");
`endif

endmodule
`default_nettype wire

@@ sim/testbench.sv @@
// Self-checking testbench for leg_motion_interpolator_ik_top: predicts servo angles per tick
// and compares every result transfer field by field. Depends on lmi_pkg and the block RTL.
`timescale 1ns / 1ps
module testbench;
  import lmi_pkg::*;

  localparam logic [1:0] KIND_NONE = 2'd3;
  localparam int DRAIN_CYCLES = 300;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 5000;

  typedef struct {
    logic [1:0] limb;
    logic joint;
    logic [15:0] angle;
    logic reached;
    logic last;
  } angle_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [55:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic m_tlast;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_addr = '0;
  logic [11:0] cfg_data = '0;

  leg_motion_interpolator_ik_top u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // predictor state
  longint cur_pos[4][3];
  longint tgt_pos[4][3];
  longint step_len[4][3];
  longint speed = 16, hip = 0;
  logic [3:0] mirror = 4'd6, flip = 4'd5;
  longint atan_tab[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                           29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

  angle_res_t angle_q[$];
  int err_count = 0;
  bit tx_gaps = 1, rx_gaps = 1, hold_req = 0;
  int idle_cycles = 0;

  function automatic longint isqrt(longint v);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic longint atan2_deg(longint y, longint x);
    longint z, nx, ny, a;
    z = 0;
    if (x == 0 && y == 0) return 0;
    x = x * 4096;
    y = y * 4096;
    if (x < 0) begin
      z = (y >= 0) ? 180 * 65536 : -180 * 65536;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 16; i++) begin
      if (y < 0) begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z = z - atan_tab[i];
      end else begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z = z + atan_tab[i];
      end
      x = nx;
      y = ny;
    end
    a = (z + 512) >>> 10;
    if (a > ANG180) a = ANG180;
    if (a < -ANG180) a = -ANG180;
    return a;
  endfunction

  function automatic longint labs(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic void push_angle(int l, bit j, longint ang, bit reached);
    angle_res_t r;
    r.limb = l[1:0];
    r.joint = j;
    r.angle = ang[15:0];
    r.reached = reached;
    r.last = (l == 3 && j);
    angle_q.push_back(r);
  endfunction

  function automatic void advance_limbs();
    longint c, g, s, x, y, z, r, pitch;
    bit reached;
    for (int l = 0; l < 4; l++) begin
      reached = 1;
      for (int a = 0; a < 3; a++) begin
        c = cur_pos[l][a];
        g = tgt_pos[l][a];
        s = step_len[l][a];
        if (labs(c - g) >= labs(s)) begin
          c = c + s;
          if (c > 32767) c = 32767;
          if (c < -32768) c = -32768;
        end else begin
          c = g;
        end
        cur_pos[l][a] = c;
        if (c != g) reached = 0;
      end
      x = cur_pos[l][0];
      y = cur_pos[l][1];
      z = cur_pos[l][2];
      if (mirror[l]) begin
        x = -x;
        y = -y;
      end
      r = isqrt(x * x + y * y) - hip;
      pitch = atan2_deg(z, r);
      push_angle(l, 0, ANG90 + atan2_deg(y, x), reached);
      push_angle(l, 1, flip[l] ? ANG90 - pitch : ANG90 + pitch, reached);
    end
  endfunction

  function automatic void apply_item(logic [1:0] kind, int limb, longint t[3], bit k[3]);
    longint d[3], sum, tot, q;
    case (kind)
      KIND_TICK: advance_limbs();
      KIND_MOVE: begin
        sum = 0;
        for (int a = 0; a < 3; a++) begin
          d[a] = k[a] ? 0 : t[a] - cur_pos[limb][a];
          sum = sum + d[a] * d[a];
        end
        tot = isqrt(sum);
        for (int a = 0; a < 3; a++) begin
          q = 0;
          if (tot != 0) begin
            q = (2 * labs(d[a]) * speed + tot) / (2 * tot);
            if (d[a] < 0) q = -q;
          end
          step_len[limb][a] = q;
          if (!k[a]) tgt_pos[limb][a] = t[a];
        end
      end
      KIND_PLACE: begin
        for (int a = 0; a < 3; a++)
          if (!k[a]) begin
            cur_pos[limb][a] = t[a];
            tgt_pos[limb][a] = t[a];
          end
      end
      default: ;
    endcase
  endfunction

  // offer one item, leave tvalid high so back-to-back items need no gap
  task automatic send_item(logic [1:0] kind, logic [1:0] limb, logic [15:0] tx,
                           logic [15:0] ty, logic [15:0] tz, bit kx, bit ky, bit kz);
    int gap;
    longint t[3];
    bit k[3];
    gap = tx_gaps ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {3'b000, kz, ky, kx, tz, ty, tx, limb};
    do @(posedge clk); while (!s_tready);
    t = '{longint'($signed(tx)), longint'($signed(ty)), longint'($signed(tz))};
    k = '{kx, ky, kz};
    apply_item(kind, limb, t, k);
  endtask

  task automatic tick();
    send_item(KIND_TICK, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (angle_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [11:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_STEP_SPEED: speed = val;
      CFG_HIP_OFFSET: hip = val;
      CFG_MIRROR: mirror = val[3:0];
      default: flip = val[3:0];
    endcase
  endtask

  // result checker
  always @(posedge clk) begin
    angle_res_t e;
    if (m_tvalid && m_tready) begin
      if (angle_q.size() == 0) begin
        $display("%0t: unexpected result transfer %h last %b", $time, m_tdata, m_tlast);
        err_count++;
      end else begin
        e = angle_q.pop_front();
        if (m_tdata[1:0] !== e.limb || m_tdata[2] !== e.joint || m_tdata[18:3] !== e.angle
            || m_tdata[19] !== e.reached || m_tlast !== e.last || m_tdata[23:20] !== 4'd0) begin
          $display("%0t: mismatch expected limb %0d joint %0d angle %0d reached %0d last %0d",
                   $time, e.limb, e.joint, $signed(e.angle), e.reached, e.last);
          $display("%0t:          actual limb %0d joint %0d angle %0d reached %0d last %0d",
                   $time, m_tdata[1:0], m_tdata[2], $signed(m_tdata[18:3]), m_tdata[19],
                   m_tlast);
          err_count++;
        end
      end
    end
  end

  // receiver: random stalls, and a long hold-off on request
  initial begin
    int n;
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 0;
      end
      n = rx_gaps ? $urandom_range(0, 5) : 0;
      if (n > 0) begin
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  task automatic test_place_and_tick();
    send_item(KIND_TICK, 0, 0, 0, 0, 0, 0, 0);
    send_item(KIND_PLACE, 0, 16'h7fff, 16'h8000, 16'h7fff, 0, 0, 0);
    send_item(KIND_PLACE, 1, 16'h8000, 16'h7fff, 16'h8000, 0, 0, 0);
    send_item(KIND_PLACE, 2, 16'h0000, 16'hffff, 16'h0001, 0, 0, 0);
    send_item(KIND_PLACE, 3, 16'h1234, 16'h5678, 16'h9abc, 1, 0, 1);
    send_item(KIND_NONE, 3, 16'hffff, 16'hffff, 16'hffff, 1, 1, 1);
    tick();
    send_item(KIND_PLACE, 2, 16'hffff, 16'h0000, 16'h8000, 0, 1, 0);
    tick();
  endtask

  task automatic test_moves();
    send_item(KIND_MOVE, 0, 16'h7fff, 16'h8000, 16'h7fff, 0, 0, 0); // zero distance
    tick();
    send_item(KIND_MOVE, 1, 16'h7fff, 16'h8000, 16'h7fff, 0, 0, 0); // full-range path
    send_item(KIND_MOVE, 2, 16'h0020, 16'hffe0, 16'h0008, 0, 0, 0);
    send_item(KIND_MOVE, 3, 16'h0000, 16'h0000, 16'h0000, 0, 1, 0);
    send_item(KIND_MOVE, 2, 16'h0000, 16'h0010, 16'h0000, 1, 0, 1);
    repeat (4) tick();
  endtask

  task automatic test_config_sweep();
    write_reg(CFG_STEP_SPEED, 12'd4095);
    write_reg(CFG_HIP_OFFSET, 12'd4095);
    write_reg(CFG_MIRROR, 4'hf);
    write_reg(CFG_FLIP, 4'h0);
    send_item(KIND_MOVE, 0, 16'h8000, 16'h7fff, 16'h0000, 0, 0, 0);
    repeat (3) tick();
    write_reg(CFG_STEP_SPEED, 12'd0);
    write_reg(CFG_HIP_OFFSET, 12'd0);
    write_reg(CFG_MIRROR, 4'h0);
    write_reg(CFG_FLIP, 4'hf);
    send_item(KIND_MOVE, 1, 16'h0100, 16'h0100, 16'h0100, 0, 0, 0);
    repeat (2) tick();
  endtask

  task automatic test_backpressure();
    drain();
    hold_req = 1;
    repeat (6) tick();
  endtask

  function automatic logic [15:0] near(longint base);
    longint v;
    v = base + $signed($urandom_range(0, 400)) - 200;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  task automatic test_random(int count);
    int sent, pick, l;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      l = $urandom_range(0, 3);
      if (pick < 8) begin
        send_item(KIND_NONE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom);
      end else if (pick < 18) begin
        send_item(KIND_PLACE, l, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        sent++;
      end else if (pick < 45) begin
        if (pick < 38)
          send_item(KIND_MOVE, l, near(cur_pos[l][0]), near(cur_pos[l][1]),
                    near(cur_pos[l][2]), $urandom_range(0, 3) == 0,
                    $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
        else
          send_item(KIND_MOVE, l, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        sent++;
        for (int i = $urandom_range(1, 4); i > 0; i--) begin
          tick();
          sent++;
        end
      end else begin
        tick();
        sent++;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_place_and_tick();
    tx_gaps = 0;
    rx_gaps = 0;
    test_moves();
    tx_gaps = 1;
    rx_gaps = 1;
    test_config_sweep();
    test_backpressure();
    write_reg(CFG_STEP_SPEED, 12'd48);
    write_reg(CFG_HIP_OFFSET, 12'd100);
    write_reg(CFG_MIRROR, 4'h9);
    write_reg(CFG_FLIP, 4'h6);
    test_random(45);
    write_reg(CFG_STEP_SPEED, $urandom_range(1, 200));
    write_reg(CFG_HIP_OFFSET, $urandom_range(0, 4095));
    write_reg(CFG_MIRROR, $urandom_range(0, 15));
    write_reg(CFG_FLIP, $urandom_range(0, 15));
    test_random(45);
    drain();
    if (err_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
